FILE: design/ftb_pkg.sv
// ftb_pkg: shared types and constants for the per-face tangent/bitangent block
// no dependencies; used by every module under design/

package ftb_pkg;

    // store geometry and fixed-point format
    localparam int VERTEX_DEPTH = 4096;
    localparam int FRAC_BITS    = 16;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int IDX_W        = 12;
    localparam int VAL_W        = 32;

    // datapath widths: deltas, products, sums of products, divider
    localparam int DELTA_W   = VAL_W + 1;
    localparam int PROD_W    = 2 * DELTA_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int TOP_W     = SUM_W + FRAC_BITS + 2;
    localparam int DIVISOR_W = SUM_W + 1;
    localparam int QUOT_W    = VAL_W + 1;
    localparam int CMP_W     = DIVISOR_W + QUOT_W;
    localparam int STEP_W    = $clog2(QUOT_W);
    localparam int LANES     = 6;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_FACE = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                     operation;
        logic [IDX_W-1:0]        vertex_slot;
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] pos_z;
        logic signed [VAL_W-1:0] tex_u;
        logic signed [VAL_W-1:0] tex_v;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } item_t;

    typedef struct packed
    {
        logic [IDX_W-1:0]        target_vertex;
        logic signed [VAL_W-1:0] tangent_x;
        logic signed [VAL_W-1:0] tangent_y;
        logic signed [VAL_W-1:0] tangent_z;
        logic signed [VAL_W-1:0] bitangent_x;
        logic signed [VAL_W-1:0] bitangent_y;
        logic signed [VAL_W-1:0] bitangent_z;
        logic                    degenerate;
        logic                    last_of_face;
    } result_t;

    // one stored vertex
    typedef struct packed
    {
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] pos_z;
        logic signed [VAL_W-1:0] tex_u;
        logic signed [VAL_W-1:0] tex_v;
    } vertex_t;

    // a fetched face as it travels from front to back
    typedef struct packed
    {
        vertex_t [2:0]          vtx;
        logic [2:0][IDX_W-1:0]  corner;
    } face_t;

    // exact difference of two Q16.16 values
    function automatic logic signed [DELTA_W-1:0] delta(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        return DELTA_W'(a) - DELTA_W'(b);
    endfunction

endpackage

FILE: design/ftb_front.sv
// ftb_front: takes items, writes loads into the vertex store, reads three corners
// per face and pushes the fetched face into the queue; uses ftb_pkg

module ftb_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ftb_pkg::item_t   item,
    output logic             push,
    output ftb_pkg::face_t   push_data,
    input  logic             full
);

    ftb_pkg::vertex_t mem [ftb_pkg::VERTEX_DEPTH];
    ftb_pkg::vertex_t rdata_reg;
    ftb_pkg::vertex_t v0_reg;
    ftb_pkg::vertex_t v1_reg;
    ftb_pkg::vertex_t wr_vertex;

    logic                                 busy_reg, busy_next;
    logic [1:0]                           cnt_reg, cnt_next;
    logic [2:0][ftb_pkg::IDX_W-1:0]       corner_reg;
    logic [2:0]                           ok_reg;
    logic [2:0]                           ok_in;
    logic                                 accept;
    logic                                 is_face;
    logic                                 slot_ok;
    logic                                 rd_en;
    logic [ftb_pkg::ADDR_W-1:0]           rd_addr;

    // item handshake
    assign accept     = item_valid && item_ready;
    assign is_face    = item.operation == ftb_pkg::OP_FACE;
    assign push       = busy_reg && cnt_reg == 2'd3 && !full;
    assign item_ready = !busy_reg || push;

    // range checks against the store depth
    assign slot_ok  = {1'b0, item.vertex_slot} < (ftb_pkg::IDX_W+1)'(ftb_pkg::VERTEX_DEPTH);
    assign ok_in[0] = {1'b0, item.corner_a} < (ftb_pkg::IDX_W+1)'(ftb_pkg::VERTEX_DEPTH);
    assign ok_in[1] = {1'b0, item.corner_b} < (ftb_pkg::IDX_W+1)'(ftb_pkg::VERTEX_DEPTH);
    assign ok_in[2] = {1'b0, item.corner_c} < (ftb_pkg::IDX_W+1)'(ftb_pkg::VERTEX_DEPTH);

    assign wr_vertex = '{pos_x: item.pos_x, pos_y: item.pos_y, pos_z: item.pos_z,
                         tex_u: item.tex_u, tex_v: item.tex_v};

    // corner read address, one corner per cycle
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = item.corner_a[ftb_pkg::ADDR_W-1:0];
        if (accept && is_face)
        begin
            rd_en = 1'b1;
        end
        else if (busy_reg && cnt_reg == 2'd1)
        begin
            rd_en   = 1'b1;
            rd_addr = corner_reg[1][ftb_pkg::ADDR_W-1:0];
        end
        else if (busy_reg && cnt_reg == 2'd2)
        begin
            rd_en   = 1'b1;
            rd_addr = corner_reg[2][ftb_pkg::ADDR_W-1:0];
        end
    end

    // vertex store
    always_ff @(posedge clk)
    begin
        if (accept && !is_face && slot_ok)
        begin
            mem[item.vertex_slot[ftb_pkg::ADDR_W-1:0]] <= wr_vertex;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // corner sequencing
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            busy_next = 1'b0;
        end
        if (accept && is_face)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd1;
        end
        else if (busy_reg && cnt_reg != 2'd3)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // face payload capture
    always_ff @(posedge clk)
    begin
        if (accept && is_face)
        begin
            corner_reg <= {item.corner_c, item.corner_b, item.corner_a};
            ok_reg     <= ok_in;
        end
        if (busy_reg && cnt_reg == 2'd1)
        begin
            v0_reg <= rdata_reg;
        end
        if (busy_reg && cnt_reg == 2'd2)
        begin
            v1_reg <= rdata_reg;
        end
    end

    // out-of-range corners read as zero
    always_comb
    begin
        push_data.corner = corner_reg;
        push_data.vtx[0] = ok_reg[0] ? v0_reg : '0;
        push_data.vtx[1] = ok_reg[1] ? v1_reg : '0;
        push_data.vtx[2] = ok_reg[2] ? rdata_reg : '0;
    end

endmodule

FILE: design/ftb_queue.sv
// ftb_queue: two-entry queue of fetched faces between front and back
// uses ftb_pkg::face_t

module ftb_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ftb_pkg::face_t  push_data,
    output logic            full,
    input  logic            pop,
    output ftb_pkg::face_t  head,
    output logic            empty
);

    ftb_pkg::face_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg, count_next;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/ftb_back.sv
// ftb_back: computes deltas, products, determinant and six rounded quotients,
// then emits one transaction per corner; uses ftb_pkg

module ftb_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  ftb_pkg::face_t    head,
    input  logic              empty,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output ftb_pkg::result_t  result
);

    typedef enum logic [5:0]
    {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_PREP = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic signed [ftb_pkg::DELTA_W-1:0] e1_reg [3];
    logic signed [ftb_pkg::DELTA_W-1:0] e2_reg [3];
    logic signed [ftb_pkg::DELTA_W-1:0] d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic [2:0][ftb_pkg::IDX_W-1:0]     corner_reg;

    logic signed [ftb_pkg::PROD_W-1:0]  pdet0_reg, pdet1_reg;
    logic signed [ftb_pkg::PROD_W-1:0]  pa_reg [ftb_pkg::LANES];
    logic signed [ftb_pkg::PROD_W-1:0]  pb_reg [ftb_pkg::LANES];

    logic signed [ftb_pkg::SUM_W-1:0]   det_reg;
    logic signed [ftb_pkg::SUM_W-1:0]   num_reg [ftb_pkg::LANES];

    logic [ftb_pkg::TOP_W-1:0]          rem_reg [ftb_pkg::LANES];
    logic [ftb_pkg::QUOT_W-1:0]         q_reg [ftb_pkg::LANES];
    logic [ftb_pkg::LANES-1:0]          neg_reg;
    logic [ftb_pkg::LANES-1:0]          sat_reg;
    logic [ftb_pkg::CMP_W-1:0]          ds_reg;
    logic [ftb_pkg::STEP_W-1:0]         step_reg;
    logic                               degen_reg;

    logic [ftb_pkg::SUM_W-1:0]          abs_d;
    logic [ftb_pkg::DIVISOR_W-1:0]      dd;
    logic [ftb_pkg::SUM_W-1:0]          abs_n [ftb_pkg::LANES];
    logic [ftb_pkg::TOP_W-1:0]          top [ftb_pkg::LANES];
    logic [ftb_pkg::LANES-1:0]          ge;
    logic [ftb_pkg::VAL_W-1:0]          fin [ftb_pkg::LANES];

    logic [ftb_pkg::VAL_W-1:0]          res_reg [ftb_pkg::LANES];
    logic [2:0][ftb_pkg::IDX_W-1:0]     res_corner_reg;
    logic                               res_degen_reg;
    logic                               res_valid_reg;
    logic [1:0]                         emit_reg;
    logic                               load_res;
    logic                               out_take;

    assign pop      = state_reg == S_IDLE && !empty;
    assign load_res = state_reg == S_DONE && !res_valid_reg;
    assign out_take = result_valid && result_ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (!empty) state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_PREP;
            S_PREP: state_next = S_DIV;
            S_DIV:  if (step_reg == '0) state_next = S_DONE;
            S_DONE: if (!res_valid_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // divider setup: magnitudes, dividend with rounding half, overflow precheck
    always_comb
    begin
        abs_d = det_reg[ftb_pkg::SUM_W-1] ? ftb_pkg::SUM_W'(-det_reg)
                                          : ftb_pkg::SUM_W'(det_reg);
        dd    = {abs_d, 1'b0};
        for (int i = 0; i < ftb_pkg::LANES; i++)
        begin
            abs_n[i] = num_reg[i][ftb_pkg::SUM_W-1] ? ftb_pkg::SUM_W'(-num_reg[i])
                                                    : ftb_pkg::SUM_W'(num_reg[i]);
            top[i]   = (ftb_pkg::TOP_W'(abs_n[i]) << (ftb_pkg::FRAC_BITS + 1))
                     + ftb_pkg::TOP_W'(abs_d);
        end
    end

    // one restoring step per lane
    always_comb
    begin
        for (int i = 0; i < ftb_pkg::LANES; i++)
        begin
            ge[i] = ftb_pkg::CMP_W'(rem_reg[i]) >= ds_reg;
        end
    end

    // saturate, apply sign, force zero on a zero determinant
    always_comb
    begin
        logic [ftb_pkg::QUOT_W-1:0] limit;
        logic [ftb_pkg::QUOT_W-1:0] mag;
        logic [ftb_pkg::QUOT_W-1:0] sgn;
        for (int i = 0; i < ftb_pkg::LANES; i++)
        begin
            limit  = neg_reg[i] ? (ftb_pkg::QUOT_W'(1) << (ftb_pkg::VAL_W - 1))
                                : ((ftb_pkg::QUOT_W'(1) << (ftb_pkg::VAL_W - 1))
                                   - ftb_pkg::QUOT_W'(1));
            mag    = (sat_reg[i] || q_reg[i] > limit) ? limit : q_reg[i];
            sgn    = neg_reg[i] ? -mag : mag;
            fin[i] = degen_reg ? '0 : sgn[ftb_pkg::VAL_W-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= ftb_pkg::delta(head.vtx[1][(4-k)*ftb_pkg::VAL_W +: ftb_pkg::VAL_W],
                                            head.vtx[0][(4-k)*ftb_pkg::VAL_W +: ftb_pkg::VAL_W]);
                e2_reg[k] <= ftb_pkg::delta(head.vtx[2][(4-k)*ftb_pkg::VAL_W +: ftb_pkg::VAL_W],
                                            head.vtx[0][(4-k)*ftb_pkg::VAL_W +: ftb_pkg::VAL_W]);
            end
            d1u_reg    <= ftb_pkg::delta(head.vtx[1].tex_u, head.vtx[0].tex_u);
            d1v_reg    <= ftb_pkg::delta(head.vtx[1].tex_v, head.vtx[0].tex_v);
            d2u_reg    <= ftb_pkg::delta(head.vtx[2].tex_u, head.vtx[0].tex_u);
            d2v_reg    <= ftb_pkg::delta(head.vtx[2].tex_v, head.vtx[0].tex_v);
            corner_reg <= head.corner;
        end

        // products: lanes 0..2 tangent, 3..5 bitangent
        if (state_reg == S_MUL)
        begin
            pdet0_reg <= d1u_reg * d2v_reg;
            pdet1_reg <= d2u_reg * d1v_reg;
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k]     <= d2v_reg * e1_reg[k];
                pb_reg[k]     <= d1v_reg * e2_reg[k];
                pa_reg[k + 3] <= d1u_reg * e2_reg[k];
                pb_reg[k + 3] <= d2u_reg * e1_reg[k];
            end
        end

        if (state_reg == S_SUM)
        begin
            det_reg <= ftb_pkg::SUM_W'(pdet0_reg) - ftb_pkg::SUM_W'(pdet1_reg);
            for (int i = 0; i < ftb_pkg::LANES; i++)
            begin
                num_reg[i] <= ftb_pkg::SUM_W'(pa_reg[i]) - ftb_pkg::SUM_W'(pb_reg[i]);
            end
        end

        if (state_reg == S_PREP)
        begin
            ds_reg    <= ftb_pkg::CMP_W'(dd) << (ftb_pkg::QUOT_W - 1);
            step_reg  <= ftb_pkg::STEP_W'(ftb_pkg::QUOT_W - 1);
            degen_reg <= det_reg == '0;
            for (int i = 0; i < ftb_pkg::LANES; i++)
            begin
                rem_reg[i] <= top[i];
                q_reg[i]   <= '0;
                neg_reg[i] <= num_reg[i][ftb_pkg::SUM_W-1] ^ det_reg[ftb_pkg::SUM_W-1];
                sat_reg[i] <= ftb_pkg::CMP_W'(top[i])
                              >= (ftb_pkg::CMP_W'(dd) << ftb_pkg::QUOT_W);
            end
        end

        if (state_reg == S_DIV)
        begin
            ds_reg   <= ds_reg >> 1;
            step_reg <= step_reg - ftb_pkg::STEP_W'(1);
            for (int i = 0; i < ftb_pkg::LANES; i++)
            begin
                q_reg[i] <= {q_reg[i][ftb_pkg::QUOT_W-2:0], ge[i]};
                if (ge[i])
                begin
                    rem_reg[i] <= rem_reg[i] - ds_reg[ftb_pkg::TOP_W-1:0];
                end
            end
        end

        if (load_res)
        begin
            res_corner_reg <= corner_reg;
            res_degen_reg  <= degen_reg;
            for (int i = 0; i < ftb_pkg::LANES; i++)
            begin
                res_reg[i] <= fin[i];
            end
        end
    end

    // result emission, one corner per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            emit_reg      <= 2'd0;
        end
        else if (load_res)
        begin
            res_valid_reg <= 1'b1;
            emit_reg      <= 2'd0;
        end
        else if (out_take)
        begin
            if (emit_reg == 2'd2)
            begin
                res_valid_reg <= 1'b0;
                emit_reg      <= 2'd0;
            end
            else
            begin
                emit_reg <= emit_reg + 2'd1;
            end
        end
    end

    assign result_valid = res_valid_reg;

    always_comb
    begin
        result.target_vertex = res_corner_reg[0];
        case (emit_reg)
            2'd1:    result.target_vertex = res_corner_reg[1];
            2'd2:    result.target_vertex = res_corner_reg[2];
            default: result.target_vertex = res_corner_reg[0];
        endcase
        result.tangent_x    = res_reg[0];
        result.tangent_y    = res_reg[1];
        result.tangent_z    = res_reg[2];
        result.bitangent_x  = res_reg[3];
        result.bitangent_y  = res_reg[4];
        result.bitangent_z  = res_reg[5];
        result.degenerate   = res_degen_reg;
        result.last_of_face = emit_reg == 2'd2;
    end

    // checks
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.degenerate) |->
            (result.tangent_x == '0 && result.tangent_y == '0 && result.tangent_z == '0 &&
             result.bitangent_x == '0 && result.bitangent_y == '0 && result.bitangent_z == '0))
        else $error("degenerate result carries nonzero vectors");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == S_MUL)
        else $error("pop did not start the multiply stage");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == '0) |=> state_reg == S_DONE)
        else $error("divider did not finish after its last step");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> (res_valid_reg && emit_reg == 2'd0))
        else $error("loaded result not presented from the first corner");

endmodule

FILE: design/face_tangent_bitangent_top.sv
// face_tangent_bitangent_top: vertex-store front, face queue and arithmetic back
// depends on ftb_pkg, ftb_front, ftb_queue, ftb_back
// Path: a face passes 3 store reads, the queue, 3 arithmetic stages (multiply, sum,
// prep), a 33-step divider and the result load before its first transaction.
// Throughput: loads 1 per cycle while no face is being fetched; faces enter one at a time
// (one store read port) while the two-entry queue has room; the back divides one face at a time.
// Reset: control state clears; the vertex store is not cleared and no entry reads valid data until written.

module face_tangent_bitangent_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ftb_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output ftb_pkg::result_t  result
);

    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    ftb_pkg::face_t push_data;
    ftb_pkg::face_t head;

    ftb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_data  (push_data),
        .full       (full)
    );

    ftb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    ftb_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
